FILE: rtl/fjot_pkg.sv
// Shared types, character codes and helpers for the flat JSON object tokenizer.
package fjot_pkg;

  // Parser phase, one-hot encoded.
  typedef enum logic [14:0] {
    PH_START    = 15'b000000000000001,
    PH_OPEN     = 15'b000000000000010,
    PH_KEYSTART = 15'b000000000000100,
    PH_KEY      = 15'b000000000001000,
    PH_KEYESC   = 15'b000000000010000,
    PH_KEYHEX   = 15'b000000000100000,
    PH_COLON    = 15'b000000001000000,
    PH_VALSTART = 15'b000000010000000,
    PH_VALSTR   = 15'b000000100000000,
    PH_VALESC   = 15'b000001000000000,
    PH_VALHEX   = 15'b000010000000000,
    PH_BARE     = 15'b000100000000000,
    PH_AFTERVAL = 15'b001000000000000,
    PH_DONE     = 15'b010000000000000,
    PH_ERROR    = 15'b100000000000000
  } phase_t;

  // Kind of a result item.
  typedef enum logic [2:0] {
    K_KEY    = 3'd0,
    K_VAL    = 3'd1,
    K_PAIR   = 3'd2,
    K_ACCEPT = 3'd3,
    K_REJECT = 3'd4
  } kind_t;

  // One result item as held in the output queue.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] chr;
    logic       last;
  } result_t;

  // Number of entries in the result queue; the head and tail pointers wrap
  // at this power of two.
  localparam int FIFO_DEPTH = 4;

  // Character codes.
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_R  = 8'h72;

  // Number of bytes copied verbatim after a backslash-u escape.
  localparam logic [2:0] HEX_COUNT = 3'd4;

  // Decode the byte that follows a backslash.
  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      CH_LOW_N: r = CH_LF;
      CH_LOW_T: r = CH_TAB;
      CH_LOW_R: r = CH_CR;
      default:  r = b;
    endcase
    return r;
  endfunction

  // Space, tab and carriage return are whitespace.
  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR);
  endfunction

endpackage

FILE: rtl/flat_json_object_tokenizer_core.sv
// Streaming tokenizer that parses each newline-terminated line as a flat JSON object.
// A byte accepted is held in the input register, parsed from there into the result queue,
// and its result items are taken from the queue head.
// Throughput: one byte per cycle while the receiver does not stall and each byte gives at
// most one result item; a backslash-u escape gives two items, which the single output port drains one by one.
// Reset (rst, synchronous) returns the parser to the opening-brace phase and empties
// the input register and the four-entry result queue.
module flat_json_object_tokenizer_core (
  input  logic       clk,
  input  logic       rst,
  // Input stream. tdata: [7:0] in_byte
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  // Output stream. tdata: [7:0] out_char
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  // tuser: [2:0] out_kind
  output logic [2:0] m_tuser,
  // tlast: run_last
  output logic       m_tlast
);
  import fjot_pkg::*;

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  // Parser state
  phase_t     ph, ph_next;
  logic [2:0] hexl, hexl_next;

  // Input register
  logic       iv;
  logic [7:0] ib;

  // Result queue
  result_t         fifo [FIFO_DEPTH];
  logic [PW-1:0]   head, tail;
  logic [CW-1:0]   cnt, cnt_after_pop, cnt_next;
  logic            pop, proc;

  // Decoded results for the byte in the input register
  logic [1:0] nres;
  result_t    r0, r1;
  logic [2:0] hex_dec;
  kind_t      str_kind;

  // Per-byte parser step
  always_comb begin
    ph_next   = ph;
    hexl_next = hexl;
    nres      = 2'd0;
    r0        = '{kind: K_KEY, chr: 8'h00, last: 1'b0};
    r1        = '{kind: K_KEY, chr: 8'h00, last: 1'b1};
    hex_dec   = hexl - 3'd1;
    str_kind  = ((ph == PH_KEY) || (ph == PH_KEYESC) || (ph == PH_KEYHEX)) ? K_KEY : K_VAL;

    if (ib == CH_LF) begin
      nres      = 2'd1;
      r0.kind   = (ph == PH_DONE) ? K_ACCEPT : K_REJECT;
      ph_next   = PH_START;
      hexl_next = 3'd0;
    end else begin
      case (ph)
        PH_START: begin
          if (ib == CH_LBRACE) ph_next = PH_OPEN;
          else if (!is_ws(ib)) ph_next = PH_ERROR;
        end
        PH_OPEN: begin
          if (ib == CH_RBRACE) ph_next = PH_DONE;
          else if (ib == CH_QUOTE) ph_next = PH_KEY;
          else if (!is_ws(ib)) ph_next = PH_ERROR;
        end
        PH_KEYSTART: begin
          if (ib == CH_QUOTE) ph_next = PH_KEY;
          else if (!is_ws(ib)) ph_next = PH_ERROR;
        end
        PH_KEY, PH_VALSTR: begin
          if (ib == CH_QUOTE) begin
            if (ph == PH_KEY) begin
              ph_next = PH_COLON;
            end else begin
              nres    = 2'd1;
              r0.kind = K_PAIR;
              ph_next = PH_AFTERVAL;
            end
          end else if (ib == CH_BSLASH) begin
            ph_next = (ph == PH_KEY) ? PH_KEYESC : PH_VALESC;
          end else begin
            nres    = 2'd1;
            r0.kind = str_kind;
            r0.chr  = ib;
          end
        end
        PH_KEYESC, PH_VALESC: begin
          r0.kind = str_kind;
          r1.kind = str_kind;
          if (ib == CH_LOW_U) begin
            // Copy the escape introducer, then four bytes verbatim.
            nres      = 2'd2;
            r0.chr    = CH_BSLASH;
            r1.chr    = CH_LOW_U;
            hexl_next = HEX_COUNT;
            ph_next   = (ph == PH_KEYESC) ? PH_KEYHEX : PH_VALHEX;
          end else begin
            nres    = 2'd1;
            r0.chr  = unescape(ib);
            ph_next = (ph == PH_KEYESC) ? PH_KEY : PH_VALSTR;
          end
        end
        PH_KEYHEX, PH_VALHEX: begin
          nres    = 2'd1;
          r0.kind = str_kind;
          r0.chr  = ib;
          if ((hex_dec == 3'd0) || (hex_dec > HEX_COUNT)) begin
            ph_next = (ph == PH_KEYHEX) ? PH_KEY : PH_VALSTR;
          end
          hexl_next = (hex_dec > HEX_COUNT) ? 3'd0 : hex_dec;
        end
        PH_COLON: begin
          if (ib == CH_COLON) ph_next = PH_VALSTART;
          else if (!is_ws(ib)) ph_next = PH_ERROR;
        end
        PH_VALSTART: begin
          if (!is_ws(ib)) begin
            if (ib == CH_QUOTE) begin
              ph_next = PH_VALSTR;
            end else if ((ib == CH_COMMA) || (ib == CH_RBRACE)) begin
              ph_next = PH_ERROR;
            end else begin
              nres    = 2'd1;
              r0.kind = K_VAL;
              r0.chr  = ib;
              ph_next = PH_BARE;
            end
          end
        end
        PH_BARE: begin
          nres = 2'd1;
          if (ib == CH_COMMA) begin
            r0.kind = K_PAIR;
            ph_next = PH_KEYSTART;
          end else if (ib == CH_RBRACE) begin
            r0.kind = K_PAIR;
            ph_next = PH_DONE;
          end else if ((ib == CH_SPACE) || (ib == CH_TAB)) begin
            r0.kind = K_PAIR;
            ph_next = PH_AFTERVAL;
          end else begin
            r0.kind = K_VAL;
            r0.chr  = ib;
          end
        end
        PH_AFTERVAL: begin
          if (ib == CH_COMMA) ph_next = PH_KEYSTART;
          else if (ib == CH_RBRACE) ph_next = PH_DONE;
          else if (!is_ws(ib)) ph_next = PH_ERROR;
        end
        PH_DONE: begin
          ph_next = PH_DONE;
        end
        default: begin
          ph_next = PH_ERROR;
        end
      endcase
    end

    // The last item caused by this byte carries tlast.
    r0.last = (nres == 2'd1);
  end

  // Queue accounting: parse a byte only when two free entries remain after this pop.
  always_comb begin
    pop           = m_tvalid && m_tready;
    cnt_after_pop = cnt - {{(CW-1){1'b0}}, pop};
    proc          = iv && (cnt_after_pop <= CW'(FIFO_DEPTH - 2));
    cnt_next      = cnt_after_pop + (proc ? {{(CW-2){1'b0}}, nres} : {CW{1'b0}});
  end

  assign s_tready = !iv || proc;

  // Output port is driven from the queue head.
  assign m_tvalid = (cnt != '0);
  assign m_tdata  = fifo[head].chr;
  assign m_tuser  = fifo[head].kind;
  assign m_tlast  = fifo[head].last;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= PH_START;
      hexl <= 3'd0;
      iv   <= 1'b0;
      head <= '0;
      tail <= '0;
      cnt  <= '0;
    end else begin
      if (proc) begin
        ph   <= ph_next;
        hexl <= hexl_next;
        tail <= tail + PW'(nres);
      end
      if (s_tready) begin
        iv <= s_tvalid;
      end
      if (pop) begin
        head <= head + PW'(1);
      end
      cnt <= cnt_next;
    end
  end

  // Payload registers: input byte and queue entries
  always_ff @(posedge clk) begin
    if (s_tready) begin
      ib <= s_tdata;
    end
    if (proc && (nres != 2'd0)) begin
      fifo[tail] <= r0;
    end
    if (proc && (nres == 2'd2)) begin
      fifo[tail + PW'(1)] <= r1;
    end
  end

  // The queue never holds more items than it has entries.
  assert property (@(posedge clk) disable iff (rst) cnt <= CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  // A parsed newline always returns the parser to the opening-brace phase.
  assert property (@(posedge clk) disable iff (rst)
    (proc && (ib == CH_LF)) |=> (ph == PH_START) && (hexl == 3'd0))
    else $error("parser not reset at line end");

  // The escape byte counter is idle outside the verbatim-copy phases.
  assert property (@(posedge clk) disable iff (rst)
    ((ph != PH_KEYHEX) && (ph != PH_VALHEX)) |-> (hexl == 3'd0))
    else $error("escape counter active outside copy phase");

  // A parsed byte that gives results leaves the queue non-empty.
  assert property (@(posedge clk) disable iff (rst)
    (proc && (nres != 2'd0)) |=> m_tvalid)
    else $error("parsed results missing from queue");

endmodule

FILE: tb/flat_json_object_tokenizer_core_test.sv
// Testbench for the flat JSON object tokenizer core: directed and random lines checked per item.
`timescale 1ns / 1ps
module flat_json_object_tokenizer_core_test;
  import fjot_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 20;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [2:0] m_tuser;
  logic       m_tlast;

  // Tokens the parser must still produce, oldest first.
  result_t    expected_tokens[$];
  // Bytes of the line being built by the random generator.
  logic [7:0] line_bytes[$];

  // Parser state mirrored by the testbench.
  phase_t     line_phase = PH_START;
  logic [2:0] hex_left   = 3'd0;

  bit src_idle   = 1'b0;
  bit sink_stall = 1'b0;
  int fail_count  = 0;
  int cycle_count = 0;

  flat_json_object_tokenizer_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic result_t token(input kind_t k, input logic [7:0] c);
    result_t t;
    t.kind = k;
    t.chr  = c;
    t.last = 1'b0;
    return t;
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_CR;
  endfunction

  function automatic logic [7:0] decode_escape(input logic [7:0] b);
    if (b == CH_LOW_N) return CH_LF;
    if (b == CH_LOW_T) return CH_TAB;
    if (b == CH_LOW_R) return CH_CR;
    return b;
  endfunction

  // Advance the mirrored parser by one byte and queue the tokens it yields.
  task automatic parse_byte(input logic [7:0] b);
    result_t toks[$];
    phase_t  nxt;
    bit      in_key;
    kind_t   char_kind;
    nxt       = line_phase;
    in_key    = line_phase == PH_KEY || line_phase == PH_KEYESC || line_phase == PH_KEYHEX;
    char_kind = in_key ? K_KEY : K_VAL;
    if (b == CH_LF) begin
      toks.insert(toks.size(), token(line_phase == PH_DONE ? K_ACCEPT : K_REJECT, 8'h00));
      nxt      = PH_START;
      hex_left = 3'd0;
    end else begin
      case (line_phase)
        PH_START: begin
          if (b == CH_LBRACE) nxt = PH_OPEN;
          else if (!is_blank(b)) nxt = PH_ERROR;
        end
        PH_OPEN: begin
          if (b == CH_RBRACE) nxt = PH_DONE;
          else if (b == CH_QUOTE) nxt = PH_KEY;
          else if (!is_blank(b)) nxt = PH_ERROR;
        end
        PH_KEYSTART: begin
          if (b == CH_QUOTE) nxt = PH_KEY;
          else if (!is_blank(b)) nxt = PH_ERROR;
        end
        PH_KEY, PH_VALSTR: begin
          if (b == CH_QUOTE) begin
            if (in_key) begin
              nxt = PH_COLON;
            end else begin
              toks.insert(toks.size(), token(K_PAIR, 8'h00));
              nxt = PH_AFTERVAL;
            end
          end else if (b == CH_BSLASH) begin
            nxt = in_key ? PH_KEYESC : PH_VALESC;
          end else begin
            toks.insert(toks.size(), token(char_kind, b));
          end
        end
        PH_KEYESC, PH_VALESC: begin
          if (b == CH_LOW_U) begin
            // The escape itself is copied, then the next bytes verbatim.
            toks.insert(toks.size(), token(char_kind, CH_BSLASH));
            toks.insert(toks.size(), token(char_kind, CH_LOW_U));
            hex_left = HEX_COUNT;
            nxt      = in_key ? PH_KEYHEX : PH_VALHEX;
          end else begin
            toks.insert(toks.size(), token(char_kind, decode_escape(b)));
            nxt = in_key ? PH_KEY : PH_VALSTR;
          end
        end
        PH_KEYHEX, PH_VALHEX: begin
          toks.insert(toks.size(), token(char_kind, b));
          hex_left = hex_left - 3'd1;
          if (hex_left == 3'd0 || hex_left > HEX_COUNT) nxt = in_key ? PH_KEY : PH_VALSTR;
          if (hex_left > HEX_COUNT) hex_left = 3'd0;
        end
        PH_COLON: begin
          if (b == CH_COLON) nxt = PH_VALSTART;
          else if (!is_blank(b)) nxt = PH_ERROR;
        end
        PH_VALSTART: begin
          if (!is_blank(b)) begin
            if (b == CH_QUOTE) begin
              nxt = PH_VALSTR;
            end else if (b == CH_COMMA || b == CH_RBRACE) begin
              nxt = PH_ERROR;
            end else begin
              toks.insert(toks.size(), token(K_VAL, b));
              nxt = PH_BARE;
            end
          end
        end
        PH_BARE: begin
          if (b == CH_COMMA) begin
            toks.insert(toks.size(), token(K_PAIR, 8'h00));
            nxt = PH_KEYSTART;
          end else if (b == CH_RBRACE) begin
            toks.insert(toks.size(), token(K_PAIR, 8'h00));
            nxt = PH_DONE;
          end else if (b == CH_SPACE || b == CH_TAB) begin
            toks.insert(toks.size(), token(K_PAIR, 8'h00));
            nxt = PH_AFTERVAL;
          end else begin
            toks.insert(toks.size(), token(K_VAL, b));
          end
        end
        PH_AFTERVAL: begin
          if (b == CH_COMMA) nxt = PH_KEYSTART;
          else if (b == CH_RBRACE) nxt = PH_DONE;
          else if (!is_blank(b)) nxt = PH_ERROR;
        end
        PH_DONE: begin
        end
        default: begin
          nxt = PH_ERROR;
        end
      endcase
    end
    line_phase = nxt;
    if (toks.size() > 0) toks[toks.size() - 1].last = 1'b1;
    foreach (toks[i]) expected_tokens.insert(expected_tokens.size(), toks[i]);
  endtask

  // Compare each result item against the oldest expected token.
  always @(posedge clk) begin : check_tokens
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected item: out_kind %0d, out_char 0x%02h", m_tuser, m_tdata);
        fail_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (m_tuser !== want.kind) begin
          $error("out_kind: expected %0d, actual %0d", want.kind, m_tuser);
          fail_count++;
        end
        if (m_tdata !== want.chr) begin
          $error("out_char: expected 0x%02h, actual 0x%02h", want.chr, m_tdata);
          fail_count++;
        end
        if (m_tlast !== want.last) begin
          $error("run_last: expected %0d, actual %0d", want.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  // Receiver: stalls in random bursts while enabled.
  initial begin
    forever begin
      @(negedge clk);
      if (sink_stall && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Send one byte; called and returning at a falling edge.
  task automatic push_byte(input logic [7:0] b);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_byte(b);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_non_lf();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] pick_text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH || c == CH_LF);
    return c;
  endfunction

  function automatic bit ends_bare(input logic [7:0] c);
    return c == CH_COMMA || c == CH_RBRACE || c == CH_SPACE || c == CH_TAB || c == CH_LF;
  endfunction

  // Append one byte to the line being built.
  task automatic add_byte(input logic [7:0] b);
    line_bytes.insert(line_bytes.size(), b);
  endtask

  task automatic add_blank();
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 2))
          0: add_byte(CH_SPACE);
          1: add_byte(CH_TAB);
          default: add_byte(CH_CR);
        endcase
      end
    end
  endtask

  // Quoted string with random content and escapes of every kind.
  task automatic add_string();
    logic [7:0] c;
    add_byte(CH_QUOTE);
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(0, 5) == 0) begin
        add_byte(CH_BSLASH);
        case ($urandom_range(0, 5))
          0: add_byte(CH_LOW_N);
          1: add_byte(CH_LOW_T);
          2: add_byte(CH_LOW_R);
          3: begin
            add_byte(CH_LOW_U);
            repeat (HEX_COUNT) add_byte(pick_non_lf());
          end
          4: add_byte(CH_QUOTE);
          default: begin
            do c = pick_non_lf(); while (c == CH_LOW_U);
            add_byte(c);
          end
        endcase
      end else begin
        add_byte(pick_text_char());
      end
    end
    add_byte(CH_QUOTE);
  endtask

  // Unquoted value; carriage returns and quotes may sit inside it.
  task automatic add_bare();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (ends_bare(c) || c == CH_QUOTE || is_blank(c));
    add_byte(c);
    repeat ($urandom_range(0, 4)) begin
      do c = 8'($urandom_range(0, 255)); while (ends_bare(c));
      add_byte(c);
    end
  endtask

  // Mostly well-formed objects; some are corrupted, cut short or pure noise.
  task automatic build_line();
    int mode;
    int pairs;
    int cut;
    line_bytes.delete();
    mode = $urandom_range(0, 11);
    if (mode == 0) begin
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      add_blank();
      add_byte(CH_LBRACE);
      add_blank();
      pairs = $urandom_range(0, 4);
      for (int i = 0; i < pairs; i++) begin
        if (i > 0) begin
          add_blank();
          add_byte(CH_COMMA);
          add_blank();
        end
        add_string();
        add_blank();
        add_byte(CH_COLON);
        add_blank();
        if ($urandom_range(0, 1) == 0) add_string();
        else add_bare();
      end
      add_blank();
      add_byte(CH_RBRACE);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) add_byte(pick_non_lf());
      end
      if (mode == 1) begin
        line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (mode == 2) begin
        cut = $urandom_range(1, line_bytes.size() - 1);
        while (line_bytes.size() > cut) void'(line_bytes.pop_back());
      end
    end
    add_byte(CH_LF);
  endtask

  task automatic test_well_formed();
    send_text("{}\n");
    // Leading blanks, duplicate keys, string and bare values.
    send_text(" \t{\"id\":\"ab\", \"id\" :42}\n");
  endtask

  task automatic test_escapes();
    // Key with a backslash-u escape copying a quote and the byte extremes.
    send_text("{\"\\u\"");
    push_byte(8'h00);
    push_byte(8'hFF);
    // Value with every decoded escape, pass-through escapes and a verbatim copy.
    send_text("k\":\"\\n\\r\\t\\\\\\\"\\q\\u1\"2}\"}\n");
  endtask

  task automatic test_bare_values();
    // CR inside a bare value, ends at space and comma; trailing bytes ignored.
    send_text("{\"a\":x");
    push_byte(CH_CR);
    send_text(" ,\"b\":-,\"c\":\"\"\t}~{\n");
  endtask

  task automatic test_line_errors();
    send_text("{\"a\":,\n");
    send_text("{\"a\":}\n");
    send_text("{\"ab\n");
    send_text("{\"a\\\n");
    send_text("{\"k\":\"\\u1\n");
    send_text("{\"a\":7\n");
    send_text("x{}\n");
    // Characters of a rejected line still come out before the verdict.
    send_text("{\"a\":\"b\" q\"c\":1}\n");
  endtask

  task automatic test_random_lines(input int byte_budget, input bit idle_on);
    int sent;
    src_idle   = idle_on;
    sink_stall = idle_on;
    sent       = 0;
    while (sent < byte_budget) begin
      build_line();
      sent += line_bytes.size();
      foreach (line_bytes[i]) push_byte(line_bytes[i]);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    src_idle   = 1'b1;
    sink_stall = 1'b1;
    test_well_formed();
    test_escapes();
    test_bare_values();
    test_line_errors();
    test_random_lines(600, 1'b1);
    test_random_lines(300, 1'b0);
    test_random_lines(450, 1'b1);
    test_random_lines(250, 1'b0);
    s_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

FILE: flat_json_object_tokenizer_core.f
rtl/fjot_pkg.sv
rtl/flat_json_object_tokenizer_core.sv
tb/flat_json_object_tokenizer_core_test.sv
